### sv/mrrc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the response checker.
`timescale 1ns / 1ps
package mrrc_pkg;

  localparam int MAX_FRAME_DEF = 256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int          EXC_BIT  = 7;
  localparam int          WORD_LIMIT = 125;

  // Configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_READ_MODE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_EXP_COUNT = 1'b1;
  localparam int CFG_DW = 7;

  // Frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_CRC      = 3'd2;
  localparam logic [2:0] ST_EXC      = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  // Job queue between front and back
  localparam int JOB_DEPTH = 4;
  localparam int JOB_AW    = 2;

  localparam int OUT_DW = 40;

  typedef struct packed {
    logic        has_word;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic        has_status;
    logic [2:0]  status;
    logic [7:0]  code;
  } job_t;

  // Reflected CRC-16 update by one byte, eight shift steps unrolled
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

### sv/mrrc_front.sv
// Front end: takes received bytes, runs the CRC and framing state, queues results.
`timescale 1ns / 1ps
module mrrc_front
  import mrrc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_take,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic        read_mode,
  input  logic [6:0]  expected_count,
  output logic        job_push,
  output job_t        job
);

  localparam int PW = $clog2(MAX_FRAME + 2);
  localparam int LW = ((PW > 8) ? PW : 8) + 1;
  localparam logic [PW-1:0] P_MAX  = PW'(MAX_FRAME);
  localparam logic [PW-1:0] P_SAT  = PW'(MAX_FRAME + 1);
  localparam logic [PW-1:0] P_ONE  = PW'(1);
  localparam logic [PW-1:0] P_TWO  = PW'(2);
  localparam logic [PW-1:0] P_FIVE = PW'(5);

  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    d0_r, d0_nxt, d1_r, d1_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    func_r, func_nxt, count_r, count_nxt, code_r, code_nxt;
  logic [7:0]    hold_r, hold_nxt;

  logic [PW-1:0] pos_inc;
  logic [PW-1:0] k;
  logic [LW-1:0] k_half;
  logic          word_en, word_emit;
  logic [15:0]   crc_new;
  logic [7:0]    func_new, count_new, code_new;
  logic [15:0]   rx_crc;
  logic [2:0]    status;

  always_comb begin
    crc_new   = (pos_r >= P_TWO) ? crc_feed(crc_r, d1_r) : crc_r;
    word_en   = (pos_r >= P_FIVE) && (pos_r <= P_MAX) && read_mode && !func_r[EXC_BIT];
    k         = pos_r - P_FIVE;
    k_half    = LW'(k >> 1);
    word_emit = word_en && k[0] && (k_half < LW'(WORD_LIMIT));
    pos_inc   = (pos_r < P_SAT) ? pos_r + P_ONE : pos_r;
    func_new  = (pos_r == P_ONE) ? rx_byte : func_r;
    count_new = (pos_r == P_TWO) ? rx_byte : count_r;
    code_new  = (pos_r == P_TWO) ? rx_byte : code_r;
    // Received CRC is low byte first: the byte before this one, then this one
    rx_crc    = {rx_byte, d0_r};

    if (pos_inc < P_FIVE) begin
      status = ST_SHORT;
    end else if (rx_crc != crc_new) begin
      status = ST_CRC;
    end else if (func_new[EXC_BIT]) begin
      status = ST_EXC;
    end else if (pos_inc > P_MAX) begin
      status = ST_MISMATCH;
    end else if (read_mode && ((count_new != {expected_count, 1'b0}) ||
                               (LW'(pos_inc) != LW'(count_new) + LW'(5)))) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end

    job.has_word   = word_emit;
    job.word_value = {hold_r, d1_r};
    job.word_index = k_half[6:0];
    job.has_status = frame_end;
    job.status     = frame_end ? status : ST_OK;
    job.code       = (frame_end && status == ST_EXC) ? code_new : 8'h00;
    job_push       = byte_take && (word_emit || frame_end);
  end

  always_comb begin
    crc_nxt   = crc_r;
    d0_nxt    = d0_r;
    d1_nxt    = d1_r;
    pos_nxt   = pos_r;
    func_nxt  = func_r;
    count_nxt = count_r;
    code_nxt  = code_r;
    hold_nxt  = hold_r;
    if (byte_take) begin
      if (frame_end) begin
        // Drop all per-frame state back to its idle value
        crc_nxt   = CRC_INIT;
        d0_nxt    = 8'h00;
        d1_nxt    = 8'h00;
        pos_nxt   = '0;
        func_nxt  = 8'h00;
        count_nxt = 8'h00;
        code_nxt  = 8'h00;
        hold_nxt  = 8'h00;
      end else begin
        crc_nxt   = crc_new;
        d0_nxt    = rx_byte;
        d1_nxt    = d0_r;
        pos_nxt   = pos_inc;
        func_nxt  = func_new;
        count_nxt = count_new;
        code_nxt  = code_new;
        hold_nxt  = (word_en && !k[0]) ? d1_r : hold_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      d0_r    <= 8'h00;
      d1_r    <= 8'h00;
      pos_r   <= '0;
      func_r  <= 8'h00;
      count_r <= 8'h00;
      code_r  <= 8'h00;
      hold_r  <= 8'h00;
    end else begin
      crc_r   <= crc_nxt;
      d0_r    <= d0_nxt;
      d1_r    <= d1_nxt;
      pos_r   <= pos_nxt;
      func_r  <= func_nxt;
      count_r <= count_nxt;
      code_r  <= code_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

### sv/mrrc_fifo.sv
// Short job queue between the byte front end and the result back end.
`timescale 1ns / 1ps
module mrrc_fifo
  import mrrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              mem_r [JOB_DEPTH];
  logic [JOB_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [JOB_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (JOB_AW + 1)'(JOB_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/mrrc_back.sv
// Back end: expands queued jobs into word and status transfers through an output register.
`timescale 1ns / 1ps
module mrrc_back
  import mrrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              head,
  input  logic              empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  logic              valid_r, valid_nxt;
  logic              word_done_r, word_done_nxt;
  logic [OUT_DW-1:0] data_r, data_nxt;
  logic              kind_r, kind_nxt, last_r, last_nxt;
  logic              load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt     = valid_r;
    word_done_nxt = word_done_r;
    data_nxt      = data_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        if (head.has_word && !word_done_r) begin
          data_nxt      = {6'b0, 8'h00, ST_OK, head.word_index, head.word_value};
          kind_nxt      = 1'b0;
          last_nxt      = !head.has_status;
          pop           = !head.has_status;
          word_done_nxt = head.has_status;
        end else begin
          data_nxt      = {6'b0, head.code, head.status, 7'd0, 16'h0000};
          kind_nxt      = 1'b1;
          last_nxt      = 1'b1;
          pop           = 1'b1;
          word_done_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      word_done_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      word_done_r <= word_done_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

### sv/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: config registers, front, queue, back.
//
//  channel | dir | handshake           | contents
//  in_     | in  | in_tvalid/in_tready | tdata rx byte, tlast end of frame
//  out_    | out | out_tvalid/tready   | tdata word or status, tuser kind, tlast last
//  cfg_    | in  | cfg_we              | read mode, expected register count
//
// One byte is taken per cycle while in_tready is high; the CRC update is an
// unrolled eight-step shift network in the front end. A frame end that also
// completes a word gives two transfers from the back end. The job
// queue holds four entries, so in_tready falls only when it fills while the
// output side stalls. Reset is synchronous and active low; it clears all
// frame state and sets read mode with an expected count of one.
`timescale 1ns / 1ps
module modbus_rtu_response_checker
  import mrrc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [15:0] word_value, [22:16] word_index,
                                        // [25:23] status, [33:26] exception_code, rest zero
  output logic              out_tuser,  // [0] kind
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic       read_mode_r, read_mode_nxt;
  logic [6:0] exp_count_r, exp_count_nxt;
  logic       byte_take;
  logic       job_push, fifo_full, fifo_empty, fifo_pop;
  job_t       job, head;

  always_comb begin
    read_mode_nxt = read_mode_r;
    exp_count_nxt = exp_count_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_READ_MODE: read_mode_nxt = cfg_wdata[0];
        REG_EXP_COUNT: exp_count_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_mode_r <= 1'b1;
      exp_count_r <= 7'd1;
    end else begin
      read_mode_r <= read_mode_nxt;
      exp_count_r <= exp_count_nxt;
    end
  end

  assign in_tready = !fifo_full;
  assign byte_take = in_tvalid && in_tready;

  mrrc_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_take      (byte_take),
    .rx_byte        (in_tdata),
    .frame_end      (in_tlast),
    .read_mode      (read_mode_r),
    .expected_count (exp_count_r),
    .job_push       (job_push),
    .job            (job)
  );

  mrrc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (fifo_pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  mrrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (fifo_empty),
    .pop        (fifo_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("status transfer without last");

  a_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[33:23] == 11'd0)
    else $error("word transfer carries status or code");

  a_code_only_exc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:26] != 8'h00 |-> out_tdata[25:23] == ST_EXC)
    else $error("exception code outside exception status");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("job queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !fifo_full)
    else $error("job queue pushed while full");

endmodule
